[src/sptg_pkg.sv]
// Package with the constants, tables and pipeline types of the point-to-global-frame block.
`default_nettype none
package sptg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NSTG          = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int GUARD_BITS    = 6;

    localparam int CW = 44;
    localparam int AW = 32;
    localparam int HW = 34;
    localparam int PW = 56;
    localparam int SW = 72;
    localparam int LO_BITS = 22;

    localparam logic signed [PW-1:0] GAIN_Q24    = PW'(10187994);
    localparam logic signed [SW-1:0] ROUND_Q24   = SW'(64'd8388608);
    localparam logic signed [HW-1:0] ANG_PI      = HW'(843314857);
    localparam logic signed [HW-1:0] ANG_TWO_PI  = HW'(1686629714);
    localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(421657428);

    localparam logic signed [AW-1:0] ATAN_Q28 [ATAN_LEN] = '{
        AW'(210828714), AW'(124459457), AW'(65760959), AW'(33381290),
        AW'(16755422), AW'(8385879), AW'(4193963), AW'(2097109),
        AW'(1048571), AW'(524287), AW'(262144), AW'(131072),
        AW'(65536), AW'(32768), AW'(16384), AW'(8192),
        AW'(4096), AW'(2048), AW'(1024), AW'(512),
        AW'(256), AW'(128), AW'(64), AW'(32)
    };

    localparam int ST_IN  = 0;
    localparam int ST_V0  = 1;
    localparam int ST_G1A = NSTG + 1;
    localparam int ST_G1B = NSTG + 2;
    localparam int ST_G2A = NSTG + 3;
    localparam int ST_G2B = NSTG + 4;
    localparam int ST_H   = NSTG + 5;
    localparam int ST_R0  = NSTG + 6;
    localparam int ST_OUT = 2 * NSTG + 6;
    localparam int DEPTH  = 2 * NSTG + 7;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [AW-1:0] z;
        logic signed [AW-1:0] oz;
        logic signed [AW-1:0] theta;
        logic signed [31:0]   east;
        logic signed [31:0]   north;
        logic signed [PW-1:0] pa;
        logic signed [PW-1:0] pb;
        logic signed [PW-1:0] pc;
        logic                 sat;
    } pipe_t;

endpackage
`default_nettype wire

[src/sensor_point_to_global_frame_top.sv]
// Pipelined CORDIC transform of a sensor-frame point into the global frame.
//
// The slave channel takes one item per cycle while s_tready is high: point
// and vehicle pose. The master channel returns the global point and a
// saturation flag. The config channel writes the sensor offset; it is always
// ready; the user must write it while the pipeline is empty (not enforced).
// The pipeline has 2*NSTG+7 register stages, 39 at 16 CORDIC iterations:
// one input stage, one vectoring iteration per stage, two stages for each of
// the two gain multiplications, a heading wrap stage, one rotation iteration
// per stage (point and offset lanes side by side) and an output stage.
// Throughput is one item per cycle while the receiver keeps m_tready high.
// Each stage has its own valid bit and loads when it is empty or when the
// next stage loads, so bubbles close up and the input keeps being accepted
// while a result waits at the output. When the receiver stalls long enough
// the stages fill and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the sensor offset to zero.
`default_nettype none
module sensor_point_to_global_frame_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_right, point_forward, pose_east, pose_north, pose_heading
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // global_east, global_north
    output logic [63:0]       m_tdata,
    // saturated
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [21:0]  cfg_data
);

    localparam int CW = sptg_pkg::CW;
    localparam int AW = sptg_pkg::AW;
    localparam int HW = sptg_pkg::HW;
    localparam int PW = sptg_pkg::PW;
    localparam int SW = sptg_pkg::SW;
    localparam int DEPTH = sptg_pkg::DEPTH;
    localparam int LB = sptg_pkg::LO_BITS;
    localparam int GB = sptg_pkg::GUARD_BITS;

    logic signed [21:0] offset_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH:0]     rdy;
    sptg_pkg::pipe_t    pipe_reg  [DEPTH];
    sptg_pkg::pipe_t    pipe_next [DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = rdy[0];
    assign m_tvalid  = valid_reg[DEPTH-1];
    assign m_tdata   = {pipe_reg[DEPTH-1].north, pipe_reg[DEPTH-1].east};
    assign m_tuser   = pipe_reg[DEPTH-1].sat;
    assign rdy[DEPTH] = m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_data;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_stage
        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        if (i == sptg_pkg::ST_IN)
        begin : g_in
            always_comb
            begin
                logic signed [CW-1:0] x0;
                logic signed [CW-1:0] y0;
                logic signed [HW-1:0] th;
                x0 = CW'(signed'(s_tdata[63:32])) <<< GB;
                y0 = -(CW'(signed'(s_tdata[31:0])) <<< GB);
                th = HW'(signed'(s_tdata[143:128])) <<< 15;
                pipe_next[i] = '0;
                pipe_next[i].east  = s_tdata[95:64];
                pipe_next[i].north = s_tdata[127:96];
                pipe_next[i].ox    = CW'(offset_reg) <<< GB;
                if (th >= sptg_pkg::ANG_PI)
                begin
                    th = th - sptg_pkg::ANG_TWO_PI;
                end
                else if (th < -sptg_pkg::ANG_PI)
                begin
                    th = th + sptg_pkg::ANG_TWO_PI;
                end
                pipe_next[i].theta = th[AW-1:0];
                if (x0 < 0)
                begin
                    if (y0 >= 0)
                    begin
                        pipe_next[i].x = y0;
                        pipe_next[i].y = -x0;
                        pipe_next[i].z = sptg_pkg::ANG_HALF_PI;
                    end
                    else
                    begin
                        pipe_next[i].x = -y0;
                        pipe_next[i].y = x0;
                        pipe_next[i].z = -sptg_pkg::ANG_HALF_PI;
                    end
                end
                else
                begin
                    pipe_next[i].x = x0;
                    pipe_next[i].y = y0;
                    pipe_next[i].z = '0;
                end
            end
        end
        else if (i >= sptg_pkg::ST_V0 && i < sptg_pkg::ST_G1A)
        begin : g_vec
            localparam int K = i - sptg_pkg::ST_V0;
            always_comb
            begin
                pipe_next[i] = pipe_reg[i-1];
                if (pipe_reg[i-1].y >= 0)
                begin
                    pipe_next[i].x = pipe_reg[i-1].x + (pipe_reg[i-1].y >>> K);
                    pipe_next[i].y = pipe_reg[i-1].y - (pipe_reg[i-1].x >>> K);
                    pipe_next[i].z = pipe_reg[i-1].z + sptg_pkg::ATAN_Q28[K];
                end
                else
                begin
                    pipe_next[i].x = pipe_reg[i-1].x - (pipe_reg[i-1].y >>> K);
                    pipe_next[i].y = pipe_reg[i-1].y + (pipe_reg[i-1].x >>> K);
                    pipe_next[i].z = pipe_reg[i-1].z - sptg_pkg::ATAN_Q28[K];
                end
            end
        end
        else if (i == sptg_pkg::ST_G1A || i == sptg_pkg::ST_G2A)
        begin : g_mul
            always_comb
            begin
                logic signed [PW-1:0] hi;
                logic signed [PW-1:0] lo;
                hi = PW'(signed'(pipe_reg[i-1].x[CW-1:LB]));
                lo = PW'({1'b0, pipe_reg[i-1].x[LB-1:0]});
                pipe_next[i] = pipe_reg[i-1];
                pipe_next[i].pa = hi * sptg_pkg::GAIN_Q24;
                pipe_next[i].pb = lo * sptg_pkg::GAIN_Q24;
                pipe_next[i].pc = PW'(pipe_reg[i-1].ox) * sptg_pkg::GAIN_Q24;
            end
        end
        else if (i == sptg_pkg::ST_G1B || i == sptg_pkg::ST_G2B)
        begin : g_sum
            always_comb
            begin
                logic signed [SW-1:0] t;
                logic signed [SW-1:0] u;
                t = (SW'(pipe_reg[i-1].pa) <<< LB) + SW'(pipe_reg[i-1].pb)
                    + sptg_pkg::ROUND_Q24;
                u = SW'(pipe_reg[i-1].pc) + sptg_pkg::ROUND_Q24;
                t = t >>> 24;
                u = u >>> 24;
                pipe_next[i] = pipe_reg[i-1];
                pipe_next[i].x = t[CW-1:0];
                if (i == sptg_pkg::ST_G1B)
                begin
                    pipe_next[i].ox = u[CW-1:0];
                end
            end
        end
        else if (i == sptg_pkg::ST_H)
        begin : g_head
            always_comb
            begin
                logic signed [HW-1:0] h;
                logic signed [AW-1:0] hz;
                logic signed [AW-1:0] tz;
                h = HW'(pipe_reg[i-1].z) + HW'(pipe_reg[i-1].theta);
                if (h >= sptg_pkg::ANG_PI)
                begin
                    h = h - sptg_pkg::ANG_TWO_PI;
                end
                else if (h < -sptg_pkg::ANG_PI)
                begin
                    h = h + sptg_pkg::ANG_TWO_PI;
                end
                hz = h[AW-1:0];
                tz = pipe_reg[i-1].theta;
                pipe_next[i] = pipe_reg[i-1];
                pipe_next[i].y  = '0;
                pipe_next[i].oy = '0;
                pipe_next[i].z  = hz;
                pipe_next[i].oz = tz;
                if (hz > sptg_pkg::ANG_HALF_PI)
                begin
                    pipe_next[i].x = '0;
                    pipe_next[i].y = pipe_reg[i-1].x;
                    pipe_next[i].z = hz - sptg_pkg::ANG_HALF_PI;
                end
                else if (hz < -sptg_pkg::ANG_HALF_PI)
                begin
                    pipe_next[i].x = '0;
                    pipe_next[i].y = -pipe_reg[i-1].x;
                    pipe_next[i].z = hz + sptg_pkg::ANG_HALF_PI;
                end
                if (tz > sptg_pkg::ANG_HALF_PI)
                begin
                    pipe_next[i].ox = '0;
                    pipe_next[i].oy = pipe_reg[i-1].ox;
                    pipe_next[i].oz = tz - sptg_pkg::ANG_HALF_PI;
                end
                else if (tz < -sptg_pkg::ANG_HALF_PI)
                begin
                    pipe_next[i].ox = '0;
                    pipe_next[i].oy = -pipe_reg[i-1].ox;
                    pipe_next[i].oz = tz + sptg_pkg::ANG_HALF_PI;
                end
            end
        end
        else if (i >= sptg_pkg::ST_R0 && i < sptg_pkg::ST_OUT)
        begin : g_rot
            localparam int K = i - sptg_pkg::ST_R0;
            always_comb
            begin
                pipe_next[i] = pipe_reg[i-1];
                if (pipe_reg[i-1].z >= 0)
                begin
                    pipe_next[i].x = pipe_reg[i-1].x - (pipe_reg[i-1].y >>> K);
                    pipe_next[i].y = pipe_reg[i-1].y + (pipe_reg[i-1].x >>> K);
                    pipe_next[i].z = pipe_reg[i-1].z - sptg_pkg::ATAN_Q28[K];
                end
                else
                begin
                    pipe_next[i].x = pipe_reg[i-1].x + (pipe_reg[i-1].y >>> K);
                    pipe_next[i].y = pipe_reg[i-1].y - (pipe_reg[i-1].x >>> K);
                    pipe_next[i].z = pipe_reg[i-1].z + sptg_pkg::ATAN_Q28[K];
                end
                if (pipe_reg[i-1].oz >= 0)
                begin
                    pipe_next[i].ox = pipe_reg[i-1].ox - (pipe_reg[i-1].oy >>> K);
                    pipe_next[i].oy = pipe_reg[i-1].oy + (pipe_reg[i-1].ox >>> K);
                    pipe_next[i].oz = pipe_reg[i-1].oz - sptg_pkg::ATAN_Q28[K];
                end
                else
                begin
                    pipe_next[i].ox = pipe_reg[i-1].ox + (pipe_reg[i-1].oy >>> K);
                    pipe_next[i].oy = pipe_reg[i-1].oy - (pipe_reg[i-1].ox >>> K);
                    pipe_next[i].oz = pipe_reg[i-1].oz + sptg_pkg::ATAN_Q28[K];
                end
            end
        end
        else
        begin : g_out
            always_comb
            begin
                logic signed [CW+1:0] se;
                logic signed [CW+1:0] sn;
                logic signed [CW+1:0] ge;
                logic signed [CW+1:0] gn;
                se = ((CW+2)'(pipe_reg[i-1].x) + (CW+2)'(pipe_reg[i-1].ox)
                      + (CW+2)'(1 << (GB - 1))) >>> GB;
                sn = ((CW+2)'(pipe_reg[i-1].y) + (CW+2)'(pipe_reg[i-1].oy)
                      + (CW+2)'(1 << (GB - 1))) >>> GB;
                ge = se + (CW+2)'(pipe_reg[i-1].east);
                gn = sn + (CW+2)'(pipe_reg[i-1].north);
                pipe_next[i] = pipe_reg[i-1];
                pipe_next[i].sat = 1'b0;
                if (ge > (CW+2)'(32'sh7fffffff))
                begin
                    pipe_next[i].east = 32'sh7fffffff;
                    pipe_next[i].sat  = 1'b1;
                end
                else if (ge < -(CW+2)'(64'sh80000000))
                begin
                    pipe_next[i].east = 32'sh80000000;
                    pipe_next[i].sat  = 1'b1;
                end
                else
                begin
                    pipe_next[i].east = ge[31:0];
                end
                if (gn > (CW+2)'(32'sh7fffffff))
                begin
                    pipe_next[i].north = 32'sh7fffffff;
                    pipe_next[i].sat   = 1'b1;
                end
                else if (gn < -(CW+2)'(64'sh80000000))
                begin
                    pipe_next[i].north = 32'sh80000000;
                    pipe_next[i].sat   = 1'b1;
                end
                else
                begin
                    pipe_next[i].north = gn[31:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                if (i == 0)
                begin
                    valid_reg[i] <= s_tvalid;
                end
                else
                begin
                    valid_reg[i] <= valid_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    a_accept_fills_first : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("Accepted item did not enter the first stage.");

    a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg))
        else $error("Input blocked while the pipeline has an empty stage.");

    a_sat_means_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
             m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000))
        else $error("Saturation flag set on an unclamped result.");

endmodule
`default_nettype wire
